// File: rtl/core/box_blur_3x3_rgba_unit_macros.svh
// ----------------------------------------------------------------------------
// box blur 3x3 rgba assertion macros
// shared concurrent check wrappers for the blur core
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGBA_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bb3 same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bb3 next-cycle check failed");

`endif

// File: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// shared types and constants of the 3x3 rgba box blur
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int CHAN_W = 8;
    localparam int CHAN_N = 4;
    localparam int PIX_W  = CHAN_W * CHAN_N;

    // configuration port
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 16'd1024;

    localparam int DEF_MAX_WIDTH = 1024;

    // mean arithmetic: sum of up to nine channels, reciprocal multiply
    localparam int SUM_W        = 12;
    localparam int RECIP_W      = 14;
    localparam int RECIP_SHIFT  = 16;
    localparam int DIV4_SHIFT   = 2;
    localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;

    // channel 0 is red, in the lowest bits
    typedef logic [CHAN_N-1:0][CHAN_W-1:0] t_pix;

    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_col_pair;

endpackage

`default_nettype wire

// File: rtl/core/bb3_line_buf.sv
// ----------------------------------------------------------------------------
// bb3_line_buf
// two row memories with registered read and write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_line_buf #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire bb3_pkg::t_col_pair i_wr_data,
    output bb3_pkg::t_col_pair      o_rd_data
);

    bb3_pkg::t_pix r_mem_upper [MAX_WIDTH];
    bb3_pkg::t_pix r_mem_lower [MAX_WIDTH];

    bb3_pkg::t_pix      r_rd_upper;
    bb3_pkg::t_pix      r_rd_lower;
    logic               r_fwd;
    bb3_pkg::t_col_pair r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr] <= i_wr_data.upper;
            r_mem_lower[i_wr_addr] <= i_wr_data.lower;
        end
        if (i_rd_en) begin
            r_rd_upper <= r_mem_upper[i_rd_addr];
            r_rd_lower <= r_mem_lower[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // same entry written and read at one edge: take the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else begin
            o_rd_data.upper = r_rd_upper;
            o_rd_data.lower = r_rd_lower;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/box_blur_3x3_rgba_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba_unit
// 3x3 mean-of-valid-neighbours blur over a raster rgba pixel stream
// ----------------------------------------------------------------------------
// Takes one transfer per clock and sustains one result per clock while the
// output side keeps up. Pixels arrive in raster order; the result for pixel k
// leaves after pixel k+W+1 went in, passing the line buffer read, the window
// and sum, and the reciprocal multiply registers in turn. After the last
// pixel of a frame, W+1 drain transfers (tuser set) push out the remaining
// results, the last one flagged with tlast. A drain with nothing pending is
// taken and dropped; a pixel while results are pending drops them and starts
// a new frame. Each channel, alpha included, is the truncated mean of the
// pixels of the 3x3 neighbourhood inside the image: 9, 6 at an edge, 4 at a
// corner. Width is used clamped to 2..MAX_WIDTH and height to at least 2;
// write them only while idle. The two row memories need no clearing after
// reset, taps that read unwritten entries are always masked off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_rgba_unit_macros.svh"

module box_blur_3x3_rgba_unit #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [bb3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bb3_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // pixel input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [bb3_pkg::PIX_W-1:0]          i_s_tdata,  // red, green, blue, alpha
    input  wire logic [0:0]                         i_s_tuser,  // action (1 = drain)
    // blurred output stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [bb3_pkg::PIX_W-1:0]               o_m_tdata,  // red, green, blue, alpha
    output logic                                    o_m_tlast   // frame_end
);

    // column address, used width, pending count widths
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int PW   = $clog2(MAX_WIDTH + 2);
    localparam int CW   = (WW > bb3_pkg::CFG_WIDTH_W) ? WW : bb3_pkg::CFG_WIDTH_W;
    localparam int HW   = bb3_pkg::CFG_HEIGHT_W;
    localparam int TAPS = 9;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } t_div_sel;

    // work of one item between the read issue and the window update
    typedef struct packed {
        logic          is_pix;
        logic          emit;
        logic          last;
        logic          top_ok;
        logic          bot_ok;
        logic          left_ok;
        logic          right_ok;
        logic [AW-1:0] addr;
        bb3_pkg::t_pix pix;
    } t_s1;

    // configuration registers
    logic [bb3_pkg::CFG_WIDTH_W-1:0] r_frame_width;
    logic [HW-1:0]                   r_frame_height;

    // frame position
    logic [AW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic [PW-1:0] r_pending;

    // pipeline
    logic               r_s1_valid;
    t_s1                r_s1;
    bb3_pkg::t_pix      r_window [TAPS];
    logic               r_s2_valid;
    logic [bb3_pkg::SUM_W-1:0] r_s2_sum [bb3_pkg::CHAN_N];
    t_div_sel           r_s2_div;
    logic               r_s2_last;
    logic               r_out_valid;
    bb3_pkg::t_pix      r_out_pix;
    logic               r_out_last;

    logic [CW-1:0]      width_ext;
    logic [WW-1:0]      width_used;
    logic [HW-1:0]      height_used;

    logic               s_accept;
    logic               out_free;
    logic               en2;
    logic               s1_go;
    logic               s1_fire;
    logic               en1;

    t_s1                s0_ctl;
    logic               s0_work;
    logic [AW-1:0]      n_col;
    logic [HW-1:0]      n_row;
    logic [PW-1:0]      n_pending;

    bb3_pkg::t_col_pair rd_data;
    bb3_pkg::t_col_pair wr_data;
    logic               wr_en;

    bb3_pkg::t_pix      n_window [TAPS];
    logic [bb3_pkg::SUM_W-1:0] n_sum [bb3_pkg::CHAN_N];
    t_div_sel           n_div;
    bb3_pkg::t_pix      n_out_pix;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= bb3_pkg::RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bb3_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_wdata[bb3_pkg::CFG_WIDTH_W-1:0];
                end
                bb3_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_wdata[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp width to 2..MAX_WIDTH and height to at least 2
    always_comb begin
        width_ext = CW'(r_frame_width);
        if (width_ext < CW'(2)) begin
            width_used = WW'(2);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            width_used = WW'(MAX_WIDTH);
        end else begin
            width_used = width_ext[WW-1:0];
        end
        height_used = (r_frame_height < HW'(2)) ? HW'(2) : r_frame_height;
    end

    // ------------------------------------------------------------------
    // flow control: each stage moves when the one after it can take it
    // ------------------------------------------------------------------
    assign out_free   = !r_out_valid || i_m_tready;
    assign en2        = !r_s2_valid || out_free;
    assign s1_go      = !r_s1.emit || en2;
    assign s1_fire    = r_s1_valid && s1_go;
    assign en1        = !r_s1_valid || s1_go;
    assign o_s_tready = en1;
    assign s_accept   = i_s_tvalid && en1;

    // ------------------------------------------------------------------
    // stage 0: decode the transfer, pick the column, step the counters
    // ------------------------------------------------------------------
    always_comb begin : s0_decode
        logic [PW-1:0]   w1;
        logic [PW-1:0]   p;
        logic [AW-1:0]   x;
        logic [HW-1:0]   y;
        logic [WW-1:0]   x_ext;
        logic [WW-1:0]   x_inc;
        logic [HW:0]     y_inc;

        w1    = PW'(width_used) + PW'(1);
        p     = (r_pending > w1) ? w1 : r_pending;
        // a new pixel after a finished frame restarts at the origin
        x     = (r_pending != '0) ? '0 : r_col;
        y     = (r_pending != '0) ? '0 : r_row;
        x_ext = WW'(x);
        x_inc = x_ext + WW'(1);
        y_inc = (HW + 1)'(y) + (HW + 1)'(1);

        s0_ctl     = '0;
        s0_ctl.pix = i_s_tdata;
        s0_work    = 1'b1;
        n_col      = r_col;
        n_row      = r_row;
        n_pending  = r_pending;

        if (i_s_tuser[0]) begin
            // drain: walk the last row and one more pixel out of the line buffers
            s0_work       = (r_pending != '0);
            s0_ctl.is_pix = 1'b0;
            s0_ctl.emit   = 1'b1;
            s0_ctl.last   = (p == PW'(1));
            // a drain with nothing pending leaves the count alone
            if (s0_work) begin
                n_pending = p - PW'(1);
            end
            if (p == w1) begin
                // last pixel of the second to last row
                s0_ctl.addr     = '0;
                s0_ctl.left_ok  = 1'b1;
                s0_ctl.right_ok = 1'b0;
                s0_ctl.top_ok   = (height_used > HW'(2));
                s0_ctl.bot_ok   = 1'b1;
            end else begin
                s0_ctl.addr     = (p == PW'(1)) ? '0 : AW'(w1 - p);
                s0_ctl.left_ok  = (PW'(width_used) > p);
                s0_ctl.right_ok = (p != PW'(1));
                s0_ctl.top_ok   = 1'b1;
                s0_ctl.bot_ok   = 1'b0;
            end
        end else begin
            s0_ctl.is_pix = 1'b1;
            s0_ctl.addr   = x;
            s0_ctl.emit   = ((y != '0) && (x != '0)) || (y >= HW'(2));
            if (x != '0) begin
                // centre one column back, one row up
                s0_ctl.left_ok  = (x_ext >= WW'(2));
                s0_ctl.right_ok = (x_ext < width_used);
                s0_ctl.top_ok   = (y >= HW'(2));
                s0_ctl.bot_ok   = (y < height_used);
            end else begin
                // centre is the row end two rows up
                s0_ctl.left_ok  = 1'b1;
                s0_ctl.right_ok = 1'b0;
                s0_ctl.top_ok   = (y >= HW'(3));
                s0_ctl.bot_ok   = (y <= height_used);
            end
            n_pending = '0;
            if (x_inc >= width_used) begin
                n_col = '0;
                if (y_inc >= (HW + 1)'(height_used)) begin
                    n_row     = '0;
                    n_pending = w1;
                end else begin
                    n_row = y_inc[HW-1:0];
                end
            end else begin
                n_col = x_inc[AW-1:0];
                n_row = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pending <= '0;
        end else if (s_accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= s_accept && s0_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= s0_ctl;
        end
    end

    // ------------------------------------------------------------------
    // line buffers: read at accept, write back when the item leaves s1
    // ------------------------------------------------------------------
    assign wr_en         = s1_fire && r_s1.is_pix;
    assign wr_data.upper = rd_data.lower;
    assign wr_data.lower = r_s1.pix;

    bb3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (s0_ctl.addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // stage 1: shift the window by one column, sum the valid taps
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_window[r * 3 + 0] = r_window[r * 3 + 1];
            n_window[r * 3 + 1] = r_window[r * 3 + 2];
        end
        n_window[2] = rd_data.upper;
        n_window[5] = rd_data.lower;
        n_window[8] = r_s1.is_pix ? r_s1.pix : '0;
    end

    always_comb begin : tap_sum
        logic [2:0] row_ok;
        logic [2:0] col_ok;

        row_ok = {r_s1.bot_ok, 1'b1, r_s1.top_ok};
        col_ok = {r_s1.right_ok, 1'b1, r_s1.left_ok};
        for (int ch = 0; ch < bb3_pkg::CHAN_N; ch++) begin
            n_sum[ch] = '0;
            for (int t = 0; t < TAPS; t++) begin
                if (row_ok[t / 3] && col_ok[t % 3]) begin
                    n_sum[ch] = n_sum[ch] + bb3_pkg::SUM_W'(n_window[t][ch]);
                end
            end
        end
        // 3x3, 3x2 or 2x3, 2x2
        if ((r_s1.top_ok && r_s1.bot_ok) && (r_s1.left_ok && r_s1.right_ok)) begin
            n_div = DIV_BY_9;
        end else if ((r_s1.top_ok && r_s1.bot_ok) || (r_s1.left_ok && r_s1.right_ok)) begin
            n_div = DIV_BY_6;
        end else begin
            n_div = DIV_BY_4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_window[t] <= '0;
            end
        end else if (s1_fire) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= s1_fire && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.emit) begin
            r_s2_sum  <= n_sum;
            r_s2_div  <= n_div;
            r_s2_last <= r_s1.last;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: divide by 4, 6 or 9 (shift or reciprocal multiply)
    // ------------------------------------------------------------------
    always_comb begin : mean_div
        logic [bb3_pkg::RECIP_W-1:0]               recip;
        logic [bb3_pkg::SUM_W+bb3_pkg::RECIP_W-1:0] prod;

        recip = (r_s2_div == DIV_BY_9) ? bb3_pkg::RECIP_9 : bb3_pkg::RECIP_6;
        for (int ch = 0; ch < bb3_pkg::CHAN_N; ch++) begin
            prod = (bb3_pkg::SUM_W + bb3_pkg::RECIP_W)'(r_s2_sum[ch])
                 * (bb3_pkg::SUM_W + bb3_pkg::RECIP_W)'(recip);
            case (r_s2_div) inside
                DIV_BY_6, DIV_BY_9: begin
                    n_out_pix[ch] = prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
                end
                default: begin
                    n_out_pix[ch] = r_s2_sum[ch][bb3_pkg::DIV4_SHIFT +: bb3_pkg::CHAN_W];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_s2_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // results pending only between frames, with the position at the origin
    `BB3_ASSERT_NOW(a_pending_at_origin, i_clk, i_rst_n, r_pending != '0, (r_col == '0) && (r_row == '0))
    // a full pipe behind a stalled output refuses new transfers
    `BB3_ASSERT_NOW(a_full_pipe_stalls, i_clk, i_rst_n, r_s1_valid && r_s1.emit && r_s2_valid && r_out_valid && !i_m_tready, !o_s_tready)
    // a drain with nothing pending starts no work
    `BB3_ASSERT_NEXT(a_idle_drain_dropped, i_clk, i_rst_n, s_accept && i_s_tuser[0] && (r_pending == '0), !r_s1_valid)

endmodule

`default_nettype wire
